// ===== design/rbd_pkg.sv =====
package rbd_pkg;

    localparam int CFG_W     = 13;
    localparam int CFG_IDX_W = 2;
    localparam int CH_W      = 8;
    localparam int COORD_W   = 12;
    localparam int NUM_CH    = 4;

    localparam int MAX_SOURCE_SIDE_DEF = 4096;
    localparam int MAX_SCALE_DEF       = 64;
    localparam int SUM_LINE_DEPTH_DEF  = 2048;
    localparam int QUEUE_DEPTH         = 4;

    localparam logic [CFG_W-1:0] SOURCE_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0] SOURCE_HEIGHT_RST = 13'd480;
    localparam logic [CFG_W-1:0] MAX_SIZE_RST      = 13'd128;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SOURCE_WIDTH  = 2'd0,
        CFG_SOURCE_HEIGHT = 2'd1,
        CFG_MAX_SIZE      = 2'd2
    } t_cfg_index;

    typedef struct packed {
        logic [CH_W-1:0] in_red;
        logic [CH_W-1:0] in_green;
        logic [CH_W-1:0] in_blue;
        logic [CH_W-1:0] in_alpha;
    } t_pixel_in;

    typedef struct packed {
        logic [CH_W-1:0]    out_red;
        logic [CH_W-1:0]    out_green;
        logic [CH_W-1:0]    out_blue;
        logic [CH_W-1:0]    out_alpha;
        logic [COORD_W-1:0] out_column;
        logic [COORD_W-1:0] out_row;
        logic               frame_last;
    } t_pixel_out;

    // classification of one queued word
    typedef struct packed {
        logic pass;
        logic first;
        logic emit;
        logic last;
    } t_item_ctl;

endpackage

// ===== design/rbd_cfg.sv =====
module rbd_cfg #(
    parameter int MAX_SOURCE_SIDE = rbd_pkg::MAX_SOURCE_SIDE_DEF,
    parameter int MAX_SCALE       = rbd_pkg::MAX_SCALE_DEF
) (
    input  logic                                                      i_clk,
    input  logic                                                      i_rst_n,
    input  logic                                                      i_cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]                             i_cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]                                 i_cfg_data,
    output logic                                                      o_busy,
    output logic                                                      o_pass,
    output logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]                      o_width,
    output logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]                      o_height,
    output logic [$clog2(MAX_SCALE+1)-1:0]                            o_scale,
    output logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0]                  o_box_area,
    output logic [$clog2(MAX_SCALE*MAX_SCALE*255+1)-1:0]              o_recip,
    output logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]                      o_out_width,
    output logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]                      o_out_height
);
    import rbd_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SOURCE_SIDE+1);
    localparam int SCALE_W = $clog2(MAX_SCALE+1);
    localparam int BOX_W   = $clog2(MAX_SCALE*MAX_SCALE+1);
    localparam int SUM_W   = $clog2(MAX_SCALE*MAX_SCALE*255+1);
    localparam int NUM_W   = ((SIDE_W > CFG_W) ? SIDE_W : CFG_W) + 1;
    localparam int DIV_A   = (NUM_W > SUM_W + 1) ? NUM_W : SUM_W + 1;
    localparam int DIV_W   = (DIV_A > BOX_W) ? DIV_A : BOX_W;
    localparam int CNT_W   = $clog2(DIV_W);

    typedef enum logic [6:0] {
        ST_LOAD  = 7'b0000001,
        ST_SCALE = 7'b0000010,
        ST_BOX   = 7'b0000100,
        ST_RECIP = 7'b0001000,
        ST_OUT_W = 7'b0010000,
        ST_OUT_H = 7'b0100000,
        ST_DONE  = 7'b1000000
    } t_cfg_state;

    t_cfg_state r_state, n_state;
    logic [CFG_W-1:0]   r_src_w, n_src_w, r_src_h, n_src_h, r_max, n_max;
    logic [DIV_W-1:0]   r_rem, n_rem, r_quo, n_quo, r_dvs, n_dvs;
    logic [CNT_W-1:0]   r_cnt, n_cnt;
    logic [SCALE_W-1:0] r_scale, n_scale;
    logic [BOX_W-1:0]   r_box, n_box;
    logic [SUM_W-1:0]   r_recip, n_recip;
    logic [SIDE_W-1:0]  r_ow, n_ow, r_oh, n_oh;

    logic [SIDE_W-1:0]    w_clamped, h_clamped, longest;
    logic [NUM_W-1:0]     scale_num;
    logic [DIV_W:0]       rem_sh;
    logic                 ge;
    logic [DIV_W-1:0]     step_rem, step_quo;
    logic                 step_last;
    logic [2*SCALE_W-1:0] scale_sq;

    function automatic logic [SIDE_W-1:0] clamp_side(input logic [CFG_W-1:0] v);
        logic [NUM_W-1:0]  ext;
        logic [SIDE_W-1:0] res;
        ext = NUM_W'(v);
        if (ext == '0) begin
            res = SIDE_W'(1);
        end else if (ext > NUM_W'(MAX_SOURCE_SIDE)) begin
            res = SIDE_W'(MAX_SOURCE_SIDE);
        end else begin
            res = SIDE_W'(ext);
        end
        return res;
    endfunction

    assign w_clamped = clamp_side(r_src_w);
    assign h_clamped = clamp_side(r_src_h);
    assign longest   = (w_clamped >= h_clamped) ? w_clamped : h_clamped;
    assign scale_num = NUM_W'(longest) + NUM_W'(r_max) - NUM_W'(1);

    // one restoring step of the shared divider
    assign rem_sh    = {r_rem, r_quo[DIV_W-1]};
    assign ge        = rem_sh >= {1'b0, r_dvs};
    assign step_rem  = ge ? DIV_W'(rem_sh - {1'b0, r_dvs}) : DIV_W'(rem_sh);
    assign step_quo  = {r_quo[DIV_W-2:0], ge};
    assign step_last = r_cnt == CNT_W'(DIV_W - 1);
    assign scale_sq  = r_scale * r_scale;

    always_comb begin
        n_state = r_state;
        n_src_w = r_src_w;
        n_src_h = r_src_h;
        n_max   = r_max;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_dvs   = r_dvs;
        n_cnt   = r_cnt;
        n_scale = r_scale;
        n_box   = r_box;
        n_recip = r_recip;
        n_ow    = r_ow;
        n_oh    = r_oh;

        if ((r_state == ST_SCALE) || (r_state == ST_RECIP) ||
            (r_state == ST_OUT_W) || (r_state == ST_OUT_H)) begin
            n_rem = step_rem;
            n_quo = step_quo;
            n_cnt = r_cnt + CNT_W'(1);
        end

        unique case (r_state)
            ST_LOAD: begin
                n_rem   = '0;
                n_quo   = DIV_W'(scale_num);
                n_dvs   = DIV_W'(r_max);
                n_cnt   = '0;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                if (step_last) begin
                    // no max size, or a ratio too coarse: saturate
                    if ((r_max == '0) || (step_quo > DIV_W'(MAX_SCALE))) begin
                        n_scale = SCALE_W'(MAX_SCALE);
                    end else begin
                        n_scale = SCALE_W'(step_quo);
                    end
                    n_state = ST_BOX;
                end
            end
            ST_BOX: begin
                n_box   = BOX_W'(scale_sq);
                n_rem   = '0;
                n_quo   = DIV_W'(1) << SUM_W;
                n_dvs   = DIV_W'(scale_sq);
                n_cnt   = '0;
                n_state = ST_RECIP;
            end
            ST_RECIP: begin
                if (step_last) begin
                    n_recip = SUM_W'(step_quo);
                    n_rem   = '0;
                    n_quo   = DIV_W'(w_clamped);
                    n_dvs   = DIV_W'(r_scale);
                    n_cnt   = '0;
                    n_state = ST_OUT_W;
                end
            end
            ST_OUT_W: begin
                if (step_last) begin
                    n_ow    = SIDE_W'(step_quo);
                    n_rem   = '0;
                    n_quo   = DIV_W'(h_clamped);
                    n_dvs   = DIV_W'(r_scale);
                    n_cnt   = '0;
                    n_state = ST_OUT_H;
                end
            end
            ST_OUT_H: begin
                if (step_last) begin
                    n_oh    = SIDE_W'(step_quo);
                    n_state = ST_DONE;
                end
            end
            ST_DONE: begin
            end
            default: begin
                n_state = ST_LOAD;
            end
        endcase

        if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SOURCE_WIDTH:  n_src_w = i_cfg_data;
                CFG_SOURCE_HEIGHT: n_src_h = i_cfg_data;
                CFG_MAX_SIZE:      n_max   = i_cfg_data;
                default: begin
                end
            endcase
            n_state = ST_LOAD;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_src_w <= SOURCE_WIDTH_RST;
            r_src_h <= SOURCE_HEIGHT_RST;
            r_max   <= MAX_SIZE_RST;
        end else begin
            r_state <= n_state;
            r_src_w <= n_src_w;
            r_src_h <= n_src_h;
            r_max   <= n_max;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem   <= n_rem;
        r_quo   <= n_quo;
        r_dvs   <= n_dvs;
        r_cnt   <= n_cnt;
        r_scale <= n_scale;
        r_box   <= n_box;
        r_recip <= n_recip;
        r_ow    <= n_ow;
        r_oh    <= n_oh;
    end

    assign o_busy       = r_state != ST_DONE;
    assign o_pass       = r_scale == SCALE_W'(1);
    assign o_width      = w_clamped;
    assign o_height     = h_clamped;
    assign o_scale      = r_scale;
    assign o_box_area   = r_box;
    assign o_recip      = r_recip;
    assign o_out_width  = r_ow;
    assign o_out_height = r_oh;

endmodule

// ===== design/rbd_front.sv =====
module rbd_front #(
    parameter int MAX_SOURCE_SIDE = rbd_pkg::MAX_SOURCE_SIDE_DEF,
    parameter int MAX_SCALE       = rbd_pkg::MAX_SCALE_DEF,
    parameter int SUM_LINE_DEPTH  = rbd_pkg::SUM_LINE_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_restart,
    input  logic                                    i_busy,
    input  logic                                    i_pass,
    input  logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]    i_width,
    input  logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]    i_height,
    input  logic [$clog2(MAX_SCALE+1)-1:0]          i_scale,
    input  logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]    i_out_width,
    input  logic [$clog2(MAX_SOURCE_SIDE+1)-1:0]    i_out_height,
    input  logic                                    i_src_valid,
    output logic                                    o_src_ready,
    input  rbd_pkg::t_pixel_in                      i_src,
    input  logic                                    i_full,
    output logic                                    o_push,
    output rbd_pkg::t_pixel_in                      o_push_px,
    output logic [$clog2(SUM_LINE_DEPTH)-1:0]       o_push_addr,
    output logic [rbd_pkg::COORD_W-1:0]             o_push_col,
    output logic [rbd_pkg::COORD_W-1:0]             o_push_row,
    output rbd_pkg::t_item_ctl                      o_push_ctl
);
    import rbd_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SOURCE_SIDE+1);
    localparam int SCALE_W = $clog2(MAX_SCALE+1);
    localparam int ADDR_W  = $clog2(SUM_LINE_DEPTH);
    localparam int LIM_W   = (SIDE_W > ADDR_W + 1) ? SIDE_W : ADDR_W + 1;

    logic [SIDE_W-1:0]  r_col, n_col, r_row, n_row, r_oc, n_oc, r_orow, n_orow;
    logic [SCALE_W-1:0] r_cib, n_cib, r_rib, n_rib;

    logic               accept, in_box, box_first, box_last, src_last, out_last;
    logic [SCALE_W-1:0] cib_inc, rib_inc;
    logic [SIDE_W-1:0]  col_inc, row_inc;

    assign o_src_ready = !i_busy && !i_full;
    assign accept      = i_src_valid && o_src_ready;

    assign cib_inc = r_cib + SCALE_W'(1);
    assign rib_inc = r_rib + SCALE_W'(1);
    assign col_inc = r_col + SIDE_W'(1);
    assign row_inc = r_row + SIDE_W'(1);

    // box lies wholly inside the image and inside the sum line
    assign in_box = (r_oc < i_out_width) && (r_orow < i_out_height) &&
                    (LIM_W'(r_oc) < LIM_W'(SUM_LINE_DEPTH));
    assign box_first = (r_cib == '0) && (r_rib == '0);
    assign box_last  = (cib_inc == i_scale) && (rib_inc == i_scale);
    assign src_last  = (col_inc == i_width) && (row_inc == i_height);
    assign out_last  = ((r_oc + SIDE_W'(1)) == i_out_width) &&
                       ((r_orow + SIDE_W'(1)) == i_out_height);

    assign o_push         = accept && (i_pass || in_box);
    assign o_push_px      = i_src;
    assign o_push_addr    = ADDR_W'(r_oc);
    assign o_push_col     = i_pass ? COORD_W'(r_col) : COORD_W'(r_oc);
    assign o_push_row     = i_pass ? COORD_W'(r_row) : COORD_W'(r_orow);
    assign o_push_ctl     = '{pass:  i_pass,
                              first: i_pass || box_first,
                              emit:  i_pass || box_last,
                              last:  i_pass ? src_last : out_last};

    always_comb begin
        n_col  = r_col;
        n_row  = r_row;
        n_oc   = r_oc;
        n_orow = r_orow;
        n_cib  = r_cib;
        n_rib  = r_rib;
        if (accept) begin
            if (cib_inc >= i_scale) begin
                n_cib = '0;
                n_oc  = r_oc + SIDE_W'(1);
            end else begin
                n_cib = cib_inc;
            end
            if (col_inc >= i_width) begin
                n_col = '0;
                n_cib = '0;
                n_oc  = '0;
                n_row = row_inc;
                if (rib_inc >= i_scale) begin
                    n_rib  = '0;
                    n_orow = r_orow + SIDE_W'(1);
                end else begin
                    n_rib = rib_inc;
                end
                // end of frame
                if (row_inc >= i_height) begin
                    n_row  = '0;
                    n_rib  = '0;
                    n_orow = '0;
                end
            end else begin
                n_col = col_inc;
            end
        end
        if (i_restart) begin
            n_col  = '0;
            n_row  = '0;
            n_oc   = '0;
            n_orow = '0;
            n_cib  = '0;
            n_rib  = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col  <= '0;
            r_row  <= '0;
            r_oc   <= '0;
            r_orow <= '0;
            r_cib  <= '0;
            r_rib  <= '0;
        end else begin
            r_col  <= n_col;
            r_row  <= n_row;
            r_oc   <= n_oc;
            r_orow <= n_orow;
            r_cib  <= n_cib;
            r_rib  <= n_rib;
        end
    end

endmodule

// ===== design/rbd_fifo.sv =====
module rbd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = rbd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_slots [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr, r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             do_push, do_pop;

    assign o_full  = r_count == CNT_W'(DEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_slots[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH-1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH-1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_slots[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== design/rbd_back.sv =====
module rbd_back #(
    parameter int MAX_SCALE      = rbd_pkg::MAX_SCALE_DEF,
    parameter int SUM_LINE_DEPTH = rbd_pkg::SUM_LINE_DEPTH_DEF
) (
    input  logic                                            i_clk,
    input  logic                                            i_rst_n,
    input  logic [$clog2(MAX_SCALE*MAX_SCALE+1)-1:0]        i_box_area,
    input  logic [$clog2(MAX_SCALE*MAX_SCALE*255+1)-1:0]    i_recip,
    input  logic                                            i_empty,
    output logic                                            o_pop,
    input  rbd_pkg::t_pixel_in                              i_head_px,
    input  logic [$clog2(SUM_LINE_DEPTH)-1:0]               i_head_addr,
    input  logic [rbd_pkg::COORD_W-1:0]                     i_head_col,
    input  logic [rbd_pkg::COORD_W-1:0]                     i_head_row,
    input  rbd_pkg::t_item_ctl                              i_head_ctl,
    output logic                                            o_dst_valid,
    input  logic                                            i_dst_ready,
    output rbd_pkg::t_pixel_out                             o_dst
);
    import rbd_pkg::*;

    localparam int BOX_W  = $clog2(MAX_SCALE*MAX_SCALE+1);
    localparam int SUM_W  = $clog2(MAX_SCALE*MAX_SCALE*255+1);
    localparam int ADDR_W = $clog2(SUM_LINE_DEPTH);
    localparam int PROD_W = 2 * SUM_W;
    localparam int QD_W   = CH_W + BOX_W;

    typedef logic [NUM_CH-1:0][SUM_W-1:0] t_sums;
    typedef logic [NUM_CH-1:0][CH_W-1:0]  t_chans;
    typedef logic [NUM_CH-1:0][PROD_W-1:0] t_prods;
    typedef logic [NUM_CH-1:0][QD_W-1:0]  t_qds;

    t_sums mem_sums [SUM_LINE_DEPTH];

    logic               en, wr_en, fwd_hit;
    t_sums              base, s1_sum;
    t_chans             s1_px, s3_q, avg;
    logic [NUM_CH-1:0][SUM_W-1:0] rem;

    // stage 1: read-modify-write of the column sums
    logic               r_s1_valid;
    t_pixel_in          r_s1_px;
    logic [ADDR_W-1:0]  r_s1_addr;
    logic [COORD_W-1:0] r_s1_col, r_s1_row;
    t_item_ctl          r_s1_ctl;
    t_sums              r_rd;
    // last write, for a read that raced it
    logic               r_fw_valid;
    logic [ADDR_W-1:0]  r_fw_addr;
    t_sums              r_fw_data;
    // stage 2: sums of a finished box
    logic               r_s2_valid;
    t_sums              r_s2_sum;
    logic [COORD_W-1:0] r_s2_col, r_s2_row;
    t_item_ctl          r_s2_ctl;
    // stage 3: sum times reciprocal
    logic               r_s3_valid;
    t_sums              r_s3_sum;
    t_prods             r_s3_prod;
    logic [COORD_W-1:0] r_s3_col, r_s3_row;
    t_item_ctl          r_s3_ctl;
    // stage 4: quotient estimate times box area
    logic               r_s4_valid;
    t_sums              r_s4_sum;
    t_chans             r_s4_q;
    t_qds               r_s4_qd;
    logic [COORD_W-1:0] r_s4_col, r_s4_row;
    t_item_ctl          r_s4_ctl;
    // output word
    logic               r_out_valid;
    t_pixel_out         r_out;

    function automatic t_chans px_chans(input t_pixel_in p);
        t_chans res;
        res[0] = p.in_red;
        res[1] = p.in_green;
        res[2] = p.in_blue;
        res[3] = p.in_alpha;
        return res;
    endfunction

    assign en      = !r_out_valid || i_dst_ready;
    assign o_pop   = en && !i_empty;
    assign wr_en   = en && r_s1_valid && !r_s1_ctl.pass;
    assign fwd_hit = r_fw_valid && (r_fw_addr == r_s1_addr);
    assign base    = fwd_hit ? r_fw_data : r_rd;
    assign s1_px   = px_chans(r_s1_px);

    always_comb begin
        for (int c = 0; c < NUM_CH; c++) begin
            s1_sum[c] = r_s1_ctl.first ? SUM_W'(s1_px[c]) : base[c] + SUM_W'(s1_px[c]);
            s3_q[c]   = r_s3_prod[c][SUM_W +: CH_W];
            // estimate is exact or one short
            rem[c]    = r_s4_sum[c] - SUM_W'(r_s4_qd[c]);
            avg[c]    = r_s4_q[c] + CH_W'(rem[c] >= SUM_W'(i_box_area));
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_rd <= mem_sums[i_head_addr];
        end
        if (wr_en) begin
            mem_sums[r_s1_addr] <= s1_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_s2_valid  <= 1'b0;
            r_s3_valid  <= 1'b0;
            r_s4_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_fw_valid  <= 1'b0;
        end else begin
            if (en) begin
                r_s1_valid  <= !i_empty;
                r_s2_valid  <= r_s1_valid && r_s1_ctl.emit;
                r_s3_valid  <= r_s2_valid;
                r_s4_valid  <= r_s3_valid;
                r_out_valid <= r_s4_valid;
            end
            if (wr_en) begin
                r_fw_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_fw_addr <= r_s1_addr;
            r_fw_data <= s1_sum;
        end
        if (en) begin
            r_s1_px   <= i_head_px;
            r_s1_addr <= i_head_addr;
            r_s1_col  <= i_head_col;
            r_s1_row  <= i_head_row;
            r_s1_ctl  <= i_head_ctl;

            r_s2_sum  <= s1_sum;
            r_s2_col  <= r_s1_col;
            r_s2_row  <= r_s1_row;
            r_s2_ctl  <= r_s1_ctl;

            for (int c = 0; c < NUM_CH; c++) begin
                r_s3_prod[c] <= r_s2_sum[c] * i_recip;
                r_s4_qd[c]   <= s3_q[c] * i_box_area;
            end
            r_s3_sum  <= r_s2_sum;
            r_s3_col  <= r_s2_col;
            r_s3_row  <= r_s2_row;
            r_s3_ctl  <= r_s2_ctl;

            r_s4_sum  <= r_s3_sum;
            r_s4_q    <= s3_q;
            r_s4_col  <= r_s3_col;
            r_s4_row  <= r_s3_row;
            r_s4_ctl  <= r_s3_ctl;

            // pass-through words carry the pixel in the low sum bits
            r_out.out_red    <= r_s4_ctl.pass ? r_s4_sum[0][CH_W-1:0] : avg[0];
            r_out.out_green  <= r_s4_ctl.pass ? r_s4_sum[1][CH_W-1:0] : avg[1];
            r_out.out_blue   <= r_s4_ctl.pass ? r_s4_sum[2][CH_W-1:0] : avg[2];
            r_out.out_alpha  <= r_s4_ctl.pass ? r_s4_sum[3][CH_W-1:0] : avg[3];
            r_out.out_column <= r_s4_col;
            r_out.out_row    <= r_s4_row;
            r_out.frame_last <= r_s4_ctl.last;
        end
    end

    assign o_dst_valid = r_out_valid;
    assign o_dst       = r_out;

endmodule

// ===== design/rgba_box_downsampler.sv =====
// channel  dir  handshake                   payload
// src      in   i_src_valid / o_src_ready   i_src (rbd_pkg::t_pixel_in)
// dst      out  o_dst_valid / i_dst_ready   o_dst (rbd_pkg::t_pixel_out)
// cfg      in   i_cfg_we, taken at once     i_cfg_index, i_cfg_data
//
// one source word per cycle sustained while o_src_ready is high; a result passes the queue, the accumulator
//   stages and the output register. After reset and after every cfg write one shared bit-serial divider rebuilds
//   scale, 1/scale^2 and output size, with o_src_ready low meanwhile
// o_src_ready also drops while the 4-word queue between classifier and accumulator is full
// the accumulator pipeline halts only while o_dst is held by a low i_dst_ready
module rgba_box_downsampler #(
    parameter int MAX_SOURCE_SIDE = rbd_pkg::MAX_SOURCE_SIDE_DEF,
    parameter int MAX_SCALE       = rbd_pkg::MAX_SCALE_DEF,
    parameter int SUM_LINE_DEPTH  = rbd_pkg::SUM_LINE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [rbd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [rbd_pkg::CFG_W-1:0]       i_cfg_data,
    input  logic                            i_src_valid,
    output logic                            o_src_ready,
    input  rbd_pkg::t_pixel_in              i_src,
    output logic                            o_dst_valid,
    input  logic                            i_dst_ready,
    output rbd_pkg::t_pixel_out             o_dst
);
    import rbd_pkg::*;

    localparam int SIDE_W  = $clog2(MAX_SOURCE_SIDE+1);
    localparam int SCALE_W = $clog2(MAX_SCALE+1);
    localparam int BOX_W   = $clog2(MAX_SCALE*MAX_SCALE+1);
    localparam int SUM_W   = $clog2(MAX_SCALE*MAX_SCALE*255+1);
    localparam int ADDR_W  = $clog2(SUM_LINE_DEPTH);
    localparam int PX_W    = $bits(t_pixel_in);
    localparam int CTL_W   = $bits(t_item_ctl);
    localparam int ENT_W   = PX_W + ADDR_W + 2 * COORD_W + CTL_W;

    logic               busy, pass;
    logic [SIDE_W-1:0]  width, height, out_width, out_height;
    logic [SCALE_W-1:0] scale;
    logic [BOX_W-1:0]   box_area;
    logic [SUM_W-1:0]   recip;

    logic               push, full, pop, empty;
    t_pixel_in          push_px, head_px;
    logic [ADDR_W-1:0]  push_addr, head_addr;
    logic [COORD_W-1:0] push_col, push_row, head_col, head_row;
    t_item_ctl          push_ctl, head_ctl;
    logic [ENT_W-1:0]   push_word, head_word;

    rbd_cfg #(
        .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE),
        .MAX_SCALE       (MAX_SCALE)
    ) u_cfg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_busy       (busy),
        .o_pass       (pass),
        .o_width      (width),
        .o_height     (height),
        .o_scale      (scale),
        .o_box_area   (box_area),
        .o_recip      (recip),
        .o_out_width  (out_width),
        .o_out_height (out_height)
    );

    rbd_front #(
        .MAX_SOURCE_SIDE (MAX_SOURCE_SIDE),
        .MAX_SCALE       (MAX_SCALE),
        .SUM_LINE_DEPTH  (SUM_LINE_DEPTH)
    ) u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_restart    (i_cfg_we),
        .i_busy       (busy),
        .i_pass       (pass),
        .i_width      (width),
        .i_height     (height),
        .i_scale      (scale),
        .i_out_width  (out_width),
        .i_out_height (out_height),
        .i_src_valid  (i_src_valid),
        .o_src_ready  (o_src_ready),
        .i_src        (i_src),
        .i_full       (full),
        .o_push       (push),
        .o_push_px    (push_px),
        .o_push_addr  (push_addr),
        .o_push_col   (push_col),
        .o_push_row   (push_row),
        .o_push_ctl   (push_ctl)
    );

    assign push_word = {push_px, push_addr, push_col, push_row, push_ctl};
    assign {head_px, head_addr, head_col, head_row, head_ctl} = head_word;

    rbd_fifo #(
        .WIDTH (ENT_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (push_word),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (head_word),
        .o_empty (empty)
    );

    rbd_back #(
        .MAX_SCALE      (MAX_SCALE),
        .SUM_LINE_DEPTH (SUM_LINE_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_box_area  (box_area),
        .i_recip     (recip),
        .i_empty     (empty),
        .o_pop       (pop),
        .i_head_px   (head_px),
        .i_head_addr (head_addr),
        .i_head_col  (head_col),
        .i_head_row  (head_row),
        .i_head_ctl  (head_ctl),
        .o_dst_valid (o_dst_valid),
        .i_dst_ready (i_dst_ready),
        .o_dst       (o_dst)
    );

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    import rbd_pkg::*;

    localparam int QUIET_CYCLES = 12;
    localparam int STALL_LIMIT  = 4000;
    localparam int RANDOM_WORDS = 1800;
    localparam int IDLE_PCT     = 15;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    typedef enum logic [1:0] {
        ROW_SETTING,
        ROW_PIXEL,
        ROW_PIXEL_WANT,
        ROW_PIXEL_SILENT
    } t_row_kind;

    typedef struct {
        t_row_kind            kind;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     value;
        t_pixel_in            pixel;
        t_pixel_out           want;
    } t_row;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_data  = '0;
    logic                 src_valid = 1'b0;
    logic                 src_ready;
    t_pixel_in            src_word  = '0;
    logic                 dst_valid;
    logic                 dst_ready = 1'b0;
    t_pixel_out           dst_word;

    // mirror of the block: settings, raster counters and per-column band sums
    logic [CFG_W-1:0] frame_w_reg, frame_h_reg, max_side_reg;
    int unsigned      src_col, src_row, box_col, box_row, dst_col, dst_row;
    int unsigned      band_sum [NUM_CH][SUM_LINE_DEPTH_DEF];

    t_row       script [$];
    t_pixel_out pending [$];
    bit         calm = 1'b0;
    int         words_sent, writes_done, results_seen, mismatches, stall_count;

    rgba_box_downsampler i_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_src_valid (src_valid),
        .o_src_ready (src_ready),
        .i_src       (src_word),
        .o_dst_valid (dst_valid),
        .i_dst_ready (dst_ready),
        .o_dst       (dst_word)
    );

    initial begin
        forever #5 clk = ~clk;
    end

    function automatic void restart_frame();
        src_col = 0;
        src_row = 0;
        box_col = 0;
        box_row = 0;
        dst_col = 0;
        dst_row = 0;
    endfunction

    function automatic void mirror_write(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_W-1:0] v);
        case (idx)
            CFG_SOURCE_WIDTH:  frame_w_reg = v;
            CFG_SOURCE_HEIGHT: frame_h_reg = v;
            CFG_MAX_SIZE:      max_side_reg = v;
            default: ;
        endcase
        // any write, the spare index too, restarts the raster
        restart_frame();
    endfunction

    function automatic int unsigned clamp_side(input logic [CFG_W-1:0] v);
        if (v == 0) return 1;
        if (v > MAX_SOURCE_SIDE_DEF) return MAX_SOURCE_SIDE_DEF;
        return v;
    endfunction

    function automatic bit downsample_pixel(input t_pixel_in p, output t_pixel_out r);
        int unsigned w, h, longest, scale, ow, oh, area;
        int unsigned ch [NUM_CH];
        bit hit;
        w = clamp_side(frame_w_reg);
        h = clamp_side(frame_h_reg);
        longest = (w >= h) ? w : h;
        if (max_side_reg == 0) scale = MAX_SCALE_DEF;
        else scale = (longest + max_side_reg - 1) / max_side_reg;
        if (scale > MAX_SCALE_DEF) scale = MAX_SCALE_DEF;
        ch[0] = p.in_red;
        ch[1] = p.in_green;
        ch[2] = p.in_blue;
        ch[3] = p.in_alpha;
        r = '0;
        hit = 1'b0;
        if (scale <= 1) begin
            r.out_red = p.in_red;
            r.out_green = p.in_green;
            r.out_blue = p.in_blue;
            r.out_alpha = p.in_alpha;
            r.out_column = COORD_W'(src_col);
            r.out_row = COORD_W'(src_row);
            r.frame_last = (src_col == w - 1) && (src_row == h - 1);
            hit = 1'b1;
        end else begin
            ow = w / scale;
            oh = h / scale;
            // margins and columns past the sum line are dropped
            if (dst_col < ow && dst_row < oh && dst_col < SUM_LINE_DEPTH_DEF) begin
                for (int c = 0; c < NUM_CH; c++) begin
                    if (box_col == 0 && box_row == 0) band_sum[c][dst_col] = ch[c];
                    else band_sum[c][dst_col] = band_sum[c][dst_col] + ch[c];
                end
                if (box_col == scale - 1 && box_row == scale - 1) begin
                    area = scale * scale;
                    r.out_red = CH_W'(band_sum[0][dst_col] / area);
                    r.out_green = CH_W'(band_sum[1][dst_col] / area);
                    r.out_blue = CH_W'(band_sum[2][dst_col] / area);
                    r.out_alpha = CH_W'(band_sum[3][dst_col] / area);
                    r.out_column = COORD_W'(dst_col);
                    r.out_row = COORD_W'(dst_row);
                    r.frame_last = (dst_col == ow - 1) && (dst_row == oh - 1);
                    hit = 1'b1;
                end
            end
        end
        box_col++;
        if (box_col >= scale) begin
            box_col = 0;
            dst_col++;
        end
        src_col++;
        if (src_col >= w) begin
            src_col = 0;
            box_col = 0;
            dst_col = 0;
            box_row++;
            if (box_row >= scale) begin
                box_row = 0;
                dst_row++;
            end
            src_row++;
            if (src_row >= h) restart_frame();
        end
        return hit;
    endfunction

    function automatic t_pixel_out pass_word(input t_pixel_in p, input int col, input int row,
                                             input bit last);
        return {p, COORD_W'(col), COORD_W'(row), last};
    endfunction

    function automatic void add_setting(input logic [CFG_IDX_W-1:0] idx, input int v);
        t_row r;
        r.kind = ROW_SETTING;
        r.index = idx;
        r.value = CFG_W'(v);
        r.pixel = '0;
        r.want = '0;
        script.push_back(r);
    endfunction

    function automatic void add_pixel(input t_row_kind k, input t_pixel_in p,
                                      input t_pixel_out want);
        t_row r;
        r.kind = k;
        r.index = '0;
        r.value = '0;
        r.pixel = p;
        r.want = want;
        script.push_back(r);
    endfunction

    task automatic report_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= 40)
            $display("mismatch on %s: got %0d, expected %0d (result %0d)",
                     what, got, want, results_seen);
    endtask

    task automatic send_pixel(input t_pixel_in p);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            src_valid <= 1'b0;
            @(posedge clk);
        end
        src_valid <= 1'b1;
        src_word <= p;
        do @(posedge clk); while (!src_ready);
    endtask

    task automatic play_script();
        t_row       r;
        t_pixel_out guess;
        bit         hit;
        bit         prev_setting;
        prev_setting = 1'b0;
        while (script.size() != 0) begin
            r = script.pop_front();
            if (r.kind == ROW_SETTING) begin
                // settings only change once the block has drained
                if (!prev_setting) begin
                    src_valid <= 1'b0;
                    while (pending.size() != 0) @(posedge clk);
                    repeat (QUIET_CYCLES) @(posedge clk);
                end
                cfg_we <= 1'b1;
                cfg_index <= r.index;
                cfg_data <= r.value;
                @(posedge clk);
                mirror_write(r.index, r.value);
                writes_done++;
                if (script.size() == 0 || script[0].kind != ROW_SETTING) cfg_we <= 1'b0;
                prev_setting = 1'b1;
            end else begin
                send_pixel(r.pixel);
                words_sent++;
                hit = downsample_pixel(r.pixel, guess);
                case (r.kind)
                    ROW_PIXEL:      if (hit) pending.push_back(guess);
                    ROW_PIXEL_WANT: pending.push_back(r.want);
                    default: ;
                endcase
                prev_setting = 1'b0;
            end
        end
    endtask

    task automatic random_phase();
        int w, h, m, n, pick;
        pick = $urandom_range(0, 99);
        n = 0;
        if (pick < 55) begin
            // small frames at pass-through or box scales, one whole frame plus up to one more
            w = $urandom_range(1, 24);
            h = $urandom_range(1, 12);
            m = $urandom_range(1, 8);
            add_setting(CFG_SOURCE_WIDTH, w);
            add_setting(CFG_SOURCE_HEIGHT, h);
            add_setting(CFG_MAX_SIZE, m);
            n = w * h + $urandom_range(0, w * h);
        end else if (pick < 70) begin
            w = $urandom_range(1, 64);
            h = $urandom_range(1, 8);
            m = $urandom_range(64, 8191);
            add_setting(CFG_SOURCE_WIDTH, w);
            add_setting(CFG_SOURCE_HEIGHT, h);
            add_setting(CFG_MAX_SIZE, m);
            n = w * h + $urandom_range(0, w);
        end else if (pick < 80) begin
            case ($urandom_range(0, 5))
                0: begin w = 8191; h = $urandom_range(0, 8191); m = 0; n = 40; end
                1: begin w = 4096; h = 2; m = 2048; n = 60; end
                2: begin w = 0; h = 0; m = 8191; n = 20; end
                3: begin w = 16; h = 16; m = 1; n = 256; end
                4: begin w = 1; h = 4096; m = 64; n = 30; end
                default: begin w = 130; h = 2; m = 65; n = 260; end
            endcase
            add_setting(CFG_SOURCE_WIDTH, w);
            add_setting(CFG_SOURCE_HEIGHT, h);
            add_setting(CFG_MAX_SIZE, m);
        end else if (pick < 90) begin
            // spare index: restarts the raster mid-frame, settings kept
            add_setting(CFG_SPARE, $urandom_range(0, 8191));
            n = $urandom_range(5, 120);
        end else begin
            add_setting(CFG_MAX_SIZE, $urandom_range(1, 6));
            n = $urandom_range(20, 150);
        end
        repeat (n) add_pixel(ROW_PIXEL, $urandom(), '0);
        play_script();
    endtask

    always @(posedge clk) begin
        dst_ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    always @(posedge clk) begin : watch_dst
        t_pixel_out want;
        if (rst_n && dst_valid && dst_ready) begin
            if (pending.size() == 0) begin
                report_mismatch("word with nothing pending, column", dst_word.out_column, -1);
            end else begin
                want = pending.pop_front();
                if (dst_word.out_red != want.out_red)
                    report_mismatch("red", dst_word.out_red, want.out_red);
                if (dst_word.out_green != want.out_green)
                    report_mismatch("green", dst_word.out_green, want.out_green);
                if (dst_word.out_blue != want.out_blue)
                    report_mismatch("blue", dst_word.out_blue, want.out_blue);
                if (dst_word.out_alpha != want.out_alpha)
                    report_mismatch("alpha", dst_word.out_alpha, want.out_alpha);
                if (dst_word.out_column != want.out_column)
                    report_mismatch("column", dst_word.out_column, want.out_column);
                if (dst_word.out_row != want.out_row)
                    report_mismatch("row", dst_word.out_row, want.out_row);
                if (dst_word.frame_last != want.frame_last)
                    report_mismatch("frame_last", dst_word.frame_last, want.frame_last);
            end
            results_seen++;
        end
    end

    always @(posedge clk) begin
        if ((src_valid && src_ready) || (dst_valid && dst_ready)) stall_count <= 0;
        else stall_count <= stall_count + 1;
        if (stall_count == STALL_LIMIT) begin
            $display("watchdog: no handshake for %0d cycles, %0d results pending",
                     STALL_LIMIT, pending.size());
            $display("tb_top failed");
            $finish;
        end
    end

    initial begin
        int directed_words;
        frame_w_reg = SOURCE_WIDTH_RST;
        frame_h_reg = SOURCE_HEIGHT_RST;
        max_side_reg = MAX_SIZE_RST;
        restart_frame();
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // defaults give scale 5: the first word only opens a box
        add_pixel(ROW_PIXEL_SILENT, 32'h11223344, '0);
        // 4x2 at scale 1, every word comes straight back
        add_setting(CFG_SOURCE_WIDTH, 4);
        add_setting(CFG_SOURCE_HEIGHT, 2);
        add_setting(CFG_MAX_SIZE, 8);
        add_pixel(ROW_PIXEL_WANT, 32'h00000000, pass_word(32'h00000000, 0, 0, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'hFFFFFFFF, pass_word(32'hFFFFFFFF, 1, 0, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'h55AA55AA, pass_word(32'h55AA55AA, 2, 0, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'hAA55AA55, pass_word(32'hAA55AA55, 3, 0, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'h80000001, pass_word(32'h80000001, 0, 1, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'h7F7F7F7F, pass_word(32'h7F7F7F7F, 1, 1, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'h01020304, pass_word(32'h01020304, 2, 1, 1'b0));
        add_pixel(ROW_PIXEL_WANT, 32'hFEDCBA98, pass_word(32'hFEDCBA98, 3, 1, 1'b1));
        // 4x3 at scale 2: two boxes, then a bottom margin row
        add_setting(CFG_SOURCE_HEIGHT, 3);
        add_setting(CFG_MAX_SIZE, 2);
        add_pixel(ROW_PIXEL, 32'hFFFFFFFF, '0);
        add_pixel(ROW_PIXEL, 32'hFFFFFFFF, '0);
        add_pixel(ROW_PIXEL, 32'h00000000, '0);
        add_pixel(ROW_PIXEL, 32'hFFFFFFFF, '0);
        add_pixel(ROW_PIXEL, 32'hFFFFFFFF, '0);
        add_pixel(ROW_PIXEL_WANT, 32'hFFFFFFFF, pass_word(32'hFFFFFFFF, 0, 0, 1'b0));
        add_pixel(ROW_PIXEL, 32'h00000000, '0);
        // half-full box averages 510/4, rounded down
        add_pixel(ROW_PIXEL_WANT, 32'hFFFFFFFF, pass_word(32'h7F7F7F7F, 1, 0, 1'b1));
        add_pixel(ROW_PIXEL_SILENT, 32'h12345678, '0);
        add_pixel(ROW_PIXEL_SILENT, 32'h9ABCDEF0, '0);
        add_pixel(ROW_PIXEL_SILENT, 32'hFFFFFFFF, '0);
        add_pixel(ROW_PIXEL_SILENT, 32'h00000000, '0);
        // zero width and zero max size: scale saturates, nothing fits
        add_setting(CFG_SOURCE_WIDTH, 0);
        add_setting(CFG_SOURCE_HEIGHT, 1);
        add_setting(CFG_MAX_SIZE, 0);
        add_pixel(ROW_PIXEL_SILENT, 32'hFFFFFFFF, '0);
        add_pixel(ROW_PIXEL_SILENT, 32'h00000000, '0);
        play_script();
        directed_words = words_sent;

        while (words_sent - directed_words < RANDOM_WORDS) begin
            // one long stretch with both sides flat out
            calm = (words_sent - directed_words >= 600) && (words_sent - directed_words < 1000);
            random_phase();
        end
        calm = 1'b0;

        src_valid <= 1'b0;
        while (pending.size() != 0) @(posedge clk);
        repeat (QUIET_CYCLES) @(posedge clk);
        $display("%0d source words (%0d directed), %0d register writes, %0d results checked",
                 words_sent, directed_words, writes_done, results_seen);
        $display("frames from 1x1 to clamped 4096 wide, pass-through and box scales up to 64");
        if (mismatches == 0 && pending.size() == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule

// ===== rgba_box_downsampler.f =====
design/rbd_pkg.sv
design/rbd_cfg.sv
design/rbd_front.sv
design/rbd_fifo.sv
design/rbd_back.sv
design/rgba_box_downsampler.sv
tb/tb_top.sv
